/* hw/rtl/scrolling_text_terminal_buffer_core_defines.svh */
// Assertion macros shared by the terminal buffer RTL.
// Each expands to a labeled concurrent assertion clocked on clk, reset by arst_n.
`ifndef SCROLLING_TEXT_TERMINAL_BUFFER_CORE_DEFINES_SVH
`define SCROLLING_TEXT_TERMINAL_BUFFER_CORE_DEFINES_SVH

// same-cycle implication
`define STTB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STTB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/sttb_pkg.sv */
// Constants, request codes and character helpers for the terminal buffer.
// No dependencies.
`timescale 1ns / 1ps
package sttb_pkg;

	localparam int ROWS   = 5;
	localparam int COLS   = 21;
	localparam int CELLS  = ROWS * COLS;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLS + 1);
	localparam int ADDR_W = $clog2(CELLS);

	// port field widths
	localparam int REQ_W  = 2;
	localparam int BYTE_W = 8;
	localparam int RROW_W = 3;
	localparam int RCOL_W = 5;
	localparam int CNT_W  = 32;

	typedef logic [REQ_W-1:0]  req_t;
	typedef logic [BYTE_W-1:0] char_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [ADDR_W-1:0] addr_t;

	localparam req_t REQ_BYTE  = 2'd0;
	localparam req_t REQ_CLEAR = 2'd1;
	localparam req_t REQ_READ  = 2'd2;

	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_TILDE = 8'h7E;
	localparam char_t CH_DOT   = 8'h2E;
	localparam char_t CH_LF    = 8'h0A;
	localparam char_t CH_CR    = 8'h0D;
	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_A_M10 = 8'h37; // 'A' - 10

	function automatic char_t hex_char(input logic [3:0] n);
		char_t c;
		c = (n < 4'd10) ? (CH_ZERO + {4'h0, n}) : (CH_A_M10 + {4'h0, n});
		return c;
	endfunction

	function automatic char_t ascii_filter(input char_t b);
		char_t c;
		c = (b < CH_SPACE || b > CH_TILDE) ? CH_DOT : b;
		return c;
	endfunction

	// (a + b) mod ROWS for a sum below 2*ROWS
	function automatic row_t row_wrap(input logic [ROW_W:0] s);
		logic [ROW_W:0] t;
		t = (32'(s) >= ROWS) ? (s - (ROW_W+1)'(ROWS)) : s;
		return t[ROW_W-1:0];
	endfunction

endpackage

/* hw/rtl/sttb_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
module sttb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/scrolling_text_terminal_buffer_core.sv */
// Terminal buffer top level: sequencer, cursor, per-cell valid bits, grid RAM.
// Depends on sttb_pkg, sttb_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "scrolling_text_terminal_buffer_core_defines.svh"

// Renders received bytes into a ROWS x COLS character grid held in one RAM.
// An item is taken when start is high and busy is low; its result appears
// for exactly one cycle with done high and cannot be held off. The item
// first runs work cycles, at most one grid cell written per work cycle
// (hex mode writes the two digits and a space in turn, since the RAM has a
// single write port), then a finish state for the registered RAM read; the
// result cycle follows. busy drops in the result cycle, so a new item can be taken in it.
// Scrolling moves a row base pointer instead of data; each cell has a valid
// bit, so clear and row blanking take effect at once with no clearing pass.
// The display mode may be written only while no item is in flight.
module scrolling_text_terminal_buffer_core
	import sttb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              hex_display_we,
	input  logic              hex_display,
	input  logic              start,
	output logic              busy,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic [RROW_W-1:0] read_row,
	input  logic [RCOL_W-1:0] read_col,
	output logic              done,
	output logic [BYTE_W-1:0] cell_char,
	output logic [RROW_W-1:0] cursor_row,
	output logic [RCOL_W-1:0] cursor_col,
	output logic [CNT_W-1:0]  byte_count
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WORK = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;
	localparam logic [1:0] LAST_HEX_STEP = 2'd2;

	logic [1:0]        state_q;
	logic [1:0]        step_q;
	req_t              req_q;
	char_t             byte_q;
	logic [RROW_W-1:0] rrow_q;
	logic [RCOL_W-1:0] rcol_q;
	logic              hex_q;
	row_t              row_q;
	col_t              col_q;
	row_t              base_q;
	logic [CNT_W-1:0]  count_q;
	logic [CELLS-1:0]  vld_q;
	logic              rd_ok_q;

	logic              done_q;
	char_t             cell_q;
	logic [RROW_W-1:0] orow_q;
	logic [RCOL_W-1:0] ocol_q;
	logic [CNT_W-1:0]  ocnt_q;

	logic  work, is_byte, is_put, is_lf, adv, last_row, scroll, last_step;
	char_t put_char;
	row_t  row_n, base_n, phys_w, phys_r;
	col_t  col_w, col_n;
	addr_t waddr, raddr;
	logic  rr_ok, rd_ok;
	char_t mem_rdata;

	assign busy = (state_q != ST_IDLE);
	assign work = (state_q == ST_WORK);

	// one character cell per work cycle
	always_comb begin
		is_byte  = (req_q == REQ_BYTE);
		is_lf    = is_byte && !hex_q && (byte_q == CH_LF);
		is_put   = is_byte && (hex_q || (byte_q != CH_LF && byte_q != CH_CR));
		adv      = is_lf || (is_put && (32'(col_q) == COLS));
		last_row = (32'(row_q) == ROWS - 1);
		scroll   = adv && last_row;
		row_n    = (adv && !last_row) ? row_q + row_t'(1) : row_q;
		base_n   = scroll ? row_wrap({1'b0, base_q} + (ROW_W+1)'(1)) : base_q;
		col_w    = adv ? '0 : col_q;
		col_n    = is_put ? col_w + col_t'(1) : col_w;
		phys_w   = row_wrap({1'b0, base_n} + {1'b0, row_n});
		waddr    = ADDR_W'(32'(phys_w) * COLS + 32'(col_w));
		last_step = !is_byte || !hex_q || (step_q == LAST_HEX_STEP);

		if (hex_q) begin
			case (step_q)
				2'd0:    put_char = hex_char(byte_q[7:4]);
				2'd1:    put_char = hex_char(byte_q[3:0]);
				default: put_char = CH_SPACE;
			endcase
		end else begin
			put_char = ascii_filter(byte_q);
		end

		rr_ok  = (32'(rrow_q) < ROWS) && (32'(rcol_q) < COLS);
		phys_r = row_wrap({1'b0, base_q} + (ROW_W+1)'(rrow_q));
		raddr  = ADDR_W'(32'(phys_r) * COLS + 32'(rcol_q));
		rd_ok  = rr_ok && vld_q[raddr];
	end

	sttb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(CELLS)
	) u_grid (
		.clk  (clk),
		.we   (work && is_put),
		.waddr(waddr),
		.wdata(put_char),
		.raddr(raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			req_q   <= REQ_BYTE;
			hex_q   <= 1'b0;
			row_q   <= '0;
			col_q   <= '0;
			base_q  <= '0;
			count_q <= '0;
			vld_q   <= '0;
			rd_ok_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (hex_display_we) begin
				hex_q <= hex_display;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q   <= req_type;
						step_q  <= '0;
						state_q <= ST_WORK;
					end
				end
				ST_WORK: begin
					rd_ok_q <= (req_q == REQ_READ) && rd_ok;
					if (req_q == REQ_CLEAR) begin
						vld_q   <= '0;
						row_q   <= '0;
						col_q   <= '0;
						base_q  <= '0;
						count_q <= '0;
					end else if (is_byte) begin
						row_q  <= row_n;
						col_q  <= col_n;
						base_q <= base_n;
						// old top row becomes the blank bottom row
						for (int r = 0; r < ROWS; r++) begin
							for (int c = 0; c < COLS; c++) begin
								if (scroll && base_q == row_t'(r)) begin
									vld_q[r*COLS + c] <= 1'b0;
								end
							end
						end
						if (is_put) begin
							vld_q[waddr] <= 1'b1;
						end
						if (last_step) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
					step_q <= step_q + 2'd1;
					if (last_step) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// capture registers, payload only
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			byte_q <= rx_byte;
			rrow_q <= read_row;
			rcol_q <= read_col;
		end
		if (state_q == ST_FIN) begin
			cell_q <= rd_ok_q ? mem_rdata : '0;
			orow_q <= RROW_W'(row_q);
			ocol_q <= RCOL_W'(col_q);
			ocnt_q <= count_q;
		end
	end

	assign done       = done_q;
	assign cell_char  = cell_q;
	assign cursor_row = orow_q;
	assign cursor_col = ocol_q;
	assign byte_count = ocnt_q;

	`STTB_ASSERT_NOW(a_cursor_range, 1'b1, (32'(col_q) <= COLS) && (32'(row_q) < ROWS), "cursor out of range")
	`STTB_ASSERT_NOW(a_base_range, 1'b1, 32'(base_q) < ROWS, "row base out of range")
	`STTB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "taken item did not raise busy")
	`STTB_ASSERT_NEXT(a_done_single, done_q, !done_q, "result strobe longer than one cycle")
	`STTB_ASSERT_NOW(a_read_only_ok, rd_ok_q && state_q == ST_FIN, req_q == REQ_READ, "read data flagged on a non-read item")

endmodule
